// ----- design/ggvc_pkg.sv -----
package ggvc_pkg;

	// Field widths
	localparam int POS_W   = 16;
	localparam int DIFF_W  = 17;
	localparam int LIN_W   = 15;
	localparam int ANG_W   = 16;

	// Configuration register widths
	localparam int AGAIN_W = 12;
	localparam int LGAIN_W = 10;
	localparam int MTR_W   = 14;
	localparam int TOL_W   = 14;

	// CORDIC datapath: x and y grow by the CORDIC gain, z holds +-pi in Q.16
	localparam int CORDIC_N = 16;
	localparam int CX_W     = 20;
	localparam int CZ_W     = 20;
	localparam int BEAR_W   = CZ_W - 3;

	// Square root datapath: 34 bit sum of squares, 17 bit root
	localparam int SQ_W    = 34;
	localparam int SQRT_N  = SQ_W / 2;
	localparam int ROOT_W  = SQRT_N;
	localparam int SREM_W  = ROOT_W + 2;

	// Heading error and angular product
	localparam int ERR_W  = 18;
	localparam int PROD_W = AGAIN_W + 1 + ERR_W;

	// Divider: numerator is linear_gain * distance * 4
	localparam int NUM_W  = LGAIN_W + ROOT_W + 2;
	localparam int DIV_W  = 16;
	localparam int DREM_W = DIV_W + 1;

	// Queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Angle constants
	localparam logic signed [CZ_W-1:0]  HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [ERR_W-1:0] PI_Q13      = 18'sd25736;
	localparam logic signed [ERR_W-1:0] TWO_PI_Q13  = 18'sd51472;

	// Register map
	typedef enum logic [1:0] {
		REG_ANGULAR_GAIN   = 2'd0,
		REG_LINEAR_GAIN    = 2'd1,
		REG_MIN_TURN_RATE  = 2'd2,
		REG_GOAL_TOLERANCE = 2'd3
	} ggvc_reg_t;

	localparam logic [AGAIN_W-1:0] ANGULAR_GAIN_RST   = 12'd1280;
	localparam logic [LGAIN_W-1:0] LINEAR_GAIN_RST    = 10'd128;
	localparam logic [MTR_W-1:0]   MIN_TURN_RATE_RST  = 14'd512;
	localparam logic [TOL_W-1:0]   GOAL_TOLERANCE_RST = 14'd102;

	typedef struct packed {
		logic [AGAIN_W-1:0] angular_gain;
		logic [LGAIN_W-1:0] linear_gain;
		logic [MTR_W-1:0]   min_turn_rate;
		logic [TOL_W-1:0]   goal_tolerance;
	} ggvc_cfg_t;

	// One classified item as it travels from front to back
	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [POS_W-1:0]  heading;
		logic                     at_goal;
	} ggvc_item_t;

	// atan(2^-i) in Q.16, rounded to nearest
	function automatic logic signed [CZ_W-1:0] atan_q16(input logic [3:0] i);
		logic signed [CZ_W-1:0] r;
		case (i)
			4'd0:    r = 20'sd51472;
			4'd1:    r = 20'sd30386;
			4'd2:    r = 20'sd16055;
			4'd3:    r = 20'sd8150;
			4'd4:    r = 20'sd4091;
			4'd5:    r = 20'sd2047;
			4'd6:    r = 20'sd1024;
			4'd7:    r = 20'sd512;
			4'd8:    r = 20'sd256;
			4'd9:    r = 20'sd128;
			4'd10:   r = 20'sd64;
			4'd11:   r = 20'sd32;
			4'd12:   r = 20'sd16;
			4'd13:   r = 20'sd8;
			4'd14:   r = 20'sd4;
			4'd15:   r = 20'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/go_to_goal_velocity_controller.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// pose in  | push / full          | pose_x, pose_y, pose_heading, goal_x, goal_y
// result   | pop / empty          | linear_velocity, angular_velocity, at_goal
// config   | psel, penable, pwrite| paddr, pwdata, prdata, pready
//
// One pose beat is accepted per cycle while full is low; each result is computed by
// the 17 CORDIC/root stages and the 29 stage restoring divider.
// Reset clears all valid bits and loads the register defaults.
// A result not popped stalls the whole back pipeline; the queue and the input
// register then fill and raise full.
module go_to_goal_velocity_controller import ggvc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [POS_W-1:0]  pose_x,
	input  logic signed [POS_W-1:0]  pose_y,
	input  logic signed [POS_W-1:0]  pose_heading,
	input  logic signed [POS_W-1:0]  goal_x,
	input  logic signed [POS_W-1:0]  goal_y,
	output logic                     empty,
	input  logic                     pop,
	output logic [LIN_W-1:0]         linear_velocity,
	output logic signed [ANG_W-1:0]  angular_velocity,
	output logic                     at_goal,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [3:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	ggvc_cfg_t  cfg_q;
	ggvc_reg_t  sel;
	logic       q_push;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	ggvc_item_t q_wr_item;
	ggvc_item_t q_rd_item;

	assign pready = 1'b1;
	assign sel    = ggvc_reg_t'(paddr[3:2]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angular_gain   <= ANGULAR_GAIN_RST;
			cfg_q.linear_gain    <= LINEAR_GAIN_RST;
			cfg_q.min_turn_rate  <= MIN_TURN_RATE_RST;
			cfg_q.goal_tolerance <= GOAL_TOLERANCE_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (sel)
				REG_ANGULAR_GAIN:   cfg_q.angular_gain   <= pwdata[AGAIN_W-1:0];
				REG_LINEAR_GAIN:    cfg_q.linear_gain    <= pwdata[LGAIN_W-1:0];
				REG_MIN_TURN_RATE:  cfg_q.min_turn_rate  <= pwdata[MTR_W-1:0];
				REG_GOAL_TOLERANCE: cfg_q.goal_tolerance <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (sel)
			REG_ANGULAR_GAIN:   prdata = 32'(cfg_q.angular_gain);
			REG_LINEAR_GAIN:    prdata = 32'(cfg_q.linear_gain);
			REG_MIN_TURN_RATE:  prdata = 32'(cfg_q.min_turn_rate);
			REG_GOAL_TOLERANCE: prdata = 32'(cfg_q.goal_tolerance);
			default:            prdata = '0;
		endcase
	end

	ggvc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.pose_x         (pose_x),
		.pose_y         (pose_y),
		.pose_heading   (pose_heading),
		.goal_x         (goal_x),
		.goal_y         (goal_y),
		.goal_tolerance (cfg_q.goal_tolerance),
		.q_push         (q_push),
		.q_item         (q_wr_item),
		.q_full         (q_full)
	);

	ggvc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (q_wr_item),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_item (q_rd_item),
		.q_empty (q_empty)
	);

	ggvc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_empty          (q_empty),
		.q_item           (q_rd_item),
		.q_pop            (q_pop),
		.empty            (empty),
		.pop              (pop),
		.linear_velocity  (linear_velocity),
		.angular_velocity (angular_velocity),
		.at_goal          (at_goal)
	);

endmodule

// ----- design/ggvc_front.sv -----
module ggvc_front import ggvc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [POS_W-1:0]  pose_x,
	input  logic signed [POS_W-1:0]  pose_y,
	input  logic signed [POS_W-1:0]  pose_heading,
	input  logic signed [POS_W-1:0]  goal_x,
	input  logic signed [POS_W-1:0]  goal_y,
	input  logic [TOL_W-1:0]         goal_tolerance,
	output logic                     q_push,
	output ggvc_item_t               q_item,
	input  logic                     q_full
);

	logic                     valid_q;
	ggvc_item_t               item_q;
	logic                     accept;
	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic [DIFF_W-1:0]        adx;
	logic [DIFF_W-1:0]        ady;

	// The input holding register frees up as soon as its beat moves on
	assign full   = valid_q && q_full;
	assign accept = push && !full;
	assign q_push = valid_q && !q_full;
	assign q_item = item_q;

	// Axis errors and the arrival test
	always_comb begin
		dx  = DIFF_W'(goal_x) - DIFF_W'(pose_x);
		dy  = DIFF_W'(goal_y) - DIFF_W'(pose_y);
		adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
		ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= accept || (valid_q && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.dx      <= dx;
			item_q.dy      <= dy;
			item_q.heading <= pose_heading;
			item_q.at_goal <= (adx <= DIFF_W'(goal_tolerance)) &&
				(ady <= DIFF_W'(goal_tolerance));
		end
	end

endmodule

// ----- design/ggvc_queue.sv -----
module ggvc_queue import ggvc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  ggvc_item_t wr_item,
	output logic       q_full,
	input  logic       rd_en,
	output ggvc_item_t rd_item,
	output logic       q_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ggvc_item_t    mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	// Pointers wrap at the depth, the count tracks occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !wr_en) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !rd_en) else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |=> $stable(count_q)) else $error("count moved on pass-through");

endmodule

// ----- design/ggvc_back.sv -----
module ggvc_back import ggvc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ggvc_cfg_t                cfg,
	input  logic                     q_empty,
	input  ggvc_item_t               q_item,
	output logic                     q_pop,
	output logic                     empty,
	input  logic                     pop,
	output logic [LIN_W-1:0]         linear_velocity,
	output logic signed [ANG_W-1:0]  angular_velocity,
	output logic                     at_goal
);

	logic adv;

	// Stage 1: pre-rotation and squares
	logic                       v_s1;
	logic signed [CX_W-1:0]     x_s1;
	logic signed [CX_W-1:0]     y_s1;
	logic signed [CZ_W-1:0]     z_s1;
	logic                       zero_s1;
	logic [2*DIFF_W-3:0]        sqx_s1;
	logic [2*DIFF_W-3:0]        sqy_s1;
	logic signed [POS_W-1:0]    hd_s1;
	logic                       at_s1;

	// Stage 2: sum of squares
	logic                       v_s2;
	logic signed [CX_W-1:0]     x_s2;
	logic signed [CX_W-1:0]     y_s2;
	logic signed [CZ_W-1:0]     z_s2;
	logic                       zero_s2;
	logic [SQ_W-1:0]            sum_s2;
	logic signed [POS_W-1:0]    hd_s2;
	logic                       at_s2;

	// Shared CORDIC and square root stages, index 0 is stage 2
	logic                       c_v    [0:SQRT_N];
	logic signed [CX_W-1:0]     c_x    [0:SQRT_N];
	logic signed [CX_W-1:0]     c_y    [0:SQRT_N];
	logic signed [CZ_W-1:0]     c_z    [0:SQRT_N];
	logic                       c_zero [0:SQRT_N];
	logic [SQ_W-1:0]            c_sum  [0:SQRT_N];
	logic [SREM_W-1:0]          c_rem  [0:SQRT_N];
	logic [ROOT_W-1:0]          c_root [0:SQRT_N];
	logic signed [POS_W-1:0]    c_hd   [0:SQRT_N];
	logic                       c_at   [0:SQRT_N];

	// Stage 3: heading error, angular product, linear numerator
	logic                       v_s3;
	logic signed [PROD_W-1:0]   prod_s3;
	logic [NUM_W-1:0]           num_s3;
	logic                       at_s3;

	// Stage 4: angular command and divisor
	logic                       v_s4;
	logic signed [ANG_W-1:0]    ang_s4;
	logic [DIV_W-1:0]           div_s4;
	logic [NUM_W-1:0]           num_s4;
	logic                       at_s4;

	// Restoring divider stages, index 0 is stage 4
	logic                       d_v   [0:NUM_W];
	logic [NUM_W-1:0]           d_num [0:NUM_W];
	logic [DREM_W-1:0]          d_rem [0:NUM_W];
	logic [NUM_W-1:0]           d_quo [0:NUM_W];
	logic [DIV_W-1:0]           d_div [0:NUM_W];
	logic signed [ANG_W-1:0]    d_ang [0:NUM_W];
	logic                       d_at  [0:NUM_W];

	// Output register
	logic                       out_v_q;
	logic [LIN_W-1:0]           lin_q;
	logic signed [ANG_W-1:0]    ang_q;
	logic                       at_q;

	// The whole pipeline moves unless a finished beat waits at the output
	assign adv   = !out_v_q || pop;
	assign q_pop = adv && !q_empty;
	assign empty = !out_v_q;
	assign linear_velocity  = lin_q;
	assign angular_velocity = ang_q;
	assign at_goal          = at_q;

	// Stage 1: quadrant pre-rotation for the bearing, squares for the distance
	logic signed [CX_W-1:0] dxw;
	logic signed [CX_W-1:0] dyw;
	logic [DIFF_W-1:0]      adx;
	logic [DIFF_W-1:0]      ady;
	always_comb begin
		dxw = CX_W'(q_item.dx);
		dyw = CX_W'(q_item.dy);
		adx = q_item.dx[DIFF_W-1] ? DIFF_W'(-q_item.dx) : DIFF_W'(q_item.dx);
		ady = q_item.dy[DIFF_W-1] ? DIFF_W'(-q_item.dy) : DIFF_W'(q_item.dy);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!q_item.dx[DIFF_W-1]) begin
				x_s1 <= dxw;
				y_s1 <= dyw;
				z_s1 <= '0;
			end else if (!q_item.dy[DIFF_W-1]) begin
				x_s1 <= dyw;
				y_s1 <= -dxw;
				z_s1 <= HALF_PI_Q16;
			end else begin
				x_s1 <= -dyw;
				y_s1 <= dxw;
				z_s1 <= -HALF_PI_Q16;
			end
			zero_s1 <= (q_item.dx == '0) && (q_item.dy == '0);
			sqx_s1  <= (2*DIFF_W-2)'(adx) * (2*DIFF_W-2)'(adx);
			sqy_s1  <= (2*DIFF_W-2)'(ady) * (2*DIFF_W-2)'(ady);
			hd_s1   <= q_item.heading;
			at_s1   <= q_item.at_goal;
		end
	end

	// Stage 2: add the squares
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			zero_s2 <= zero_s1;
			sum_s2  <= SQ_W'(sqx_s1) + SQ_W'(sqy_s1);
			hd_s2   <= hd_s1;
			at_s2   <= at_s1;
		end
	end

	always_comb begin
		c_v[0]    = v_s2;
		c_x[0]    = x_s2;
		c_y[0]    = y_s2;
		c_z[0]    = z_s2;
		c_zero[0] = zero_s2;
		c_sum[0]  = sum_s2;
		c_rem[0]  = '0;
		c_root[0] = '0;
		c_hd[0]   = hd_s2;
		c_at[0]   = at_s2;
	end

	// One root digit per stage, and one CORDIC rotation in each of the first CORDIC_N stages
	for (genvar k = 0; k < SQRT_N; k++) begin : g_cs
		logic [SREM_W+1:0] t;
		logic [SREM_W+1:0] trial;
		always_comb begin
			t     = {c_rem[k], c_sum[k][SQ_W-1-2*k -: 2]};
			trial = (SREM_W+2)'({c_root[k], 2'b01});
		end

		// Valid bit of this stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_v[k+1] <= 1'b0;
			end else if (adv) begin
				c_v[k+1] <= c_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (t >= trial) begin
					c_rem[k+1]  <= SREM_W'(t - trial);
					c_root[k+1] <= {c_root[k][ROOT_W-2:0], 1'b1};
				end else begin
					c_rem[k+1]  <= SREM_W'(t);
					c_root[k+1] <= {c_root[k][ROOT_W-2:0], 1'b0};
				end
				c_sum[k+1]  <= c_sum[k];
				c_zero[k+1] <= c_zero[k];
				c_hd[k+1]   <= c_hd[k];
				c_at[k+1]   <= c_at[k];
			end
		end

		if (k < CORDIC_N) begin : g_rot
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!c_y[k][CX_W-1]) begin
						c_x[k+1] <= c_x[k] + (c_y[k] >>> k);
						c_y[k+1] <= c_y[k] - (c_x[k] >>> k);
						c_z[k+1] <= c_z[k] + atan_q16(4'(k));
					end else begin
						c_x[k+1] <= c_x[k] - (c_y[k] >>> k);
						c_y[k+1] <= c_y[k] + (c_x[k] >>> k);
						c_z[k+1] <= c_z[k] - atan_q16(4'(k));
					end
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (adv) begin
					c_x[k+1] <= c_x[k];
					c_y[k+1] <= c_y[k];
					c_z[k+1] <= c_z[k];
				end
			end
		end
	end

	// Stage 3: bearing to Q2.13, wrapped heading error, gain products
	logic signed [CZ_W-1:0]   zr;
	logic signed [BEAR_W-1:0] bear;
	logic signed [ERR_W-1:0]  err_raw;
	logic signed [ERR_W-1:0]  err;
	always_comb begin
		zr      = (c_z[SQRT_N] + CZ_W'(4)) >>> 3;
		bear    = c_zero[SQRT_N] ? '0 : BEAR_W'(zr);
		err_raw = ERR_W'(bear) - ERR_W'(c_hd[SQRT_N]);
		if (err_raw < -PI_Q13) begin
			err = err_raw + TWO_PI_Q13;
		end else if (err_raw > PI_Q13) begin
			err = err_raw - TWO_PI_Q13;
		end else begin
			err = err_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= $signed({1'b0, cfg.angular_gain}) * err;
			num_s3  <= {(LGAIN_W+ROOT_W)'(cfg.linear_gain) *
				(LGAIN_W+ROOT_W)'(c_root[SQRT_N]), 2'b00};
			at_s3   <= c_at[SQRT_N];
		end
	end

	// Stage 4: round and saturate the angular command, pick the divisor
	logic signed [PROD_W-1:0] rnd;
	logic signed [ANG_W-1:0]  ang;
	logic [DIV_W-1:0]         aabs;
	logic [DIV_W-1:0]         dsel;
	always_comb begin
		rnd = (prod_s3 + PROD_W'(1024)) >>> 11;
		if (rnd > PROD_W'(32767)) begin
			ang = 16'sh7FFF;
		end else if (rnd < -PROD_W'(32768)) begin
			ang = 16'sh8000;
		end else begin
			ang = ANG_W'(rnd);
		end
		aabs = ang[ANG_W-1] ? DIV_W'(-ang) : DIV_W'(ang);
		dsel = (aabs < DIV_W'(cfg.min_turn_rate)) ? DIV_W'(cfg.min_turn_rate) : aabs;
		if (dsel == '0) begin
			dsel = DIV_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s4 <= ang;
			div_s4 <= dsel;
			num_s4 <= num_s3;
			at_s4  <= at_s3;
		end
	end

	always_comb begin
		d_v[0]   = v_s4;
		d_num[0] = num_s4;
		d_rem[0] = '0;
		d_quo[0] = '0;
		d_div[0] = div_s4;
		d_ang[0] = ang_s4;
		d_at[0]  = at_s4;
	end

	// One quotient bit per stage
	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		logic [DREM_W:0] t;
		always_comb begin
			t = {d_rem[k], d_num[k][NUM_W-1]};
		end

		// Valid bit of this stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d_v[k+1] <= 1'b0;
			end else if (adv) begin
				d_v[k+1] <= d_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (t >= (DREM_W+1)'(d_div[k])) begin
					d_rem[k+1] <= DREM_W'(t - (DREM_W+1)'(d_div[k]));
					d_quo[k+1] <= {d_quo[k][NUM_W-2:0], 1'b1};
				end else begin
					d_rem[k+1] <= DREM_W'(t);
					d_quo[k+1] <= {d_quo[k][NUM_W-2:0], 1'b0};
				end
				d_num[k+1] <= {d_num[k][NUM_W-2:0], 1'b0};
				d_div[k+1] <= d_div[k];
				d_ang[k+1] <= d_ang[k];
				d_at[k+1]  <= d_at[k];
			end
		end
	end

	// Valid bits for the named stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= c_v[SQRT_N];
			v_s4 <= v_s3;
		end
	end

	// Output register with linear saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= d_v[NUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lin_q <= (d_quo[NUM_W] > NUM_W'(32767)) ? '1 : LIN_W'(d_quo[NUM_W]);
			ang_q <= d_ang[NUM_W];
			at_q  <= d_at[NUM_W];
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s1) && $stable(d_v[NUM_W]))) else $error("pipeline moved in stall");
	a_rose_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(d_v[NUM_W])) else $error("result without source beat");
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(d_v[NUM_W] && adv) |=> out_v_q) else $error("finished beat dropped");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("pop from empty queue");

endmodule

// ----- sim/go_to_goal_velocity_controller_checker.sv -----
`timescale 1ns / 100ps

module go_to_goal_velocity_controller_checker import ggvc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    full,
	input  logic signed [POS_W-1:0] pose_x,
	input  logic signed [POS_W-1:0] pose_y,
	input  logic signed [POS_W-1:0] pose_heading,
	input  logic signed [POS_W-1:0] goal_x,
	input  logic signed [POS_W-1:0] goal_y,
	input  logic                    empty,
	input  logic                    pop,
	input  logic [LIN_W-1:0]        linear_velocity,
	input  logic signed [ANG_W-1:0] angular_velocity,
	input  logic                    at_goal,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output int                      fail_count,
	output int                      pending
);

	typedef struct packed {
		logic [LIN_W-1:0]        lin;
		logic signed [ANG_W-1:0] ang;
		logic                    arrived;
	} command_t;

	command_t commands_due[$];

	logic [AGAIN_W-1:0] gain_ang;
	logic [LGAIN_W-1:0] gain_lin;
	logic [MTR_W-1:0]   turn_floor;
	logic [TOL_W-1:0]   tolerance;

	localparam longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
		512, 256, 128, 64, 32, 16, 8, 4, 2};

	// Bearing to the goal by CORDIC vectoring; >>> on longint floors.
	function automatic longint heading_to_goal(longint dx, longint dy);
		longint x, y, z, t;
		if (dx == 0 && dy == 0) return 0;
		x = dx; y = dy; z = 0;
		if (dx < 0) begin
			if (dy >= 0) begin
				x = dy; y = -dx; z = 102944;
			end else begin
				x = -dy; y = dx; z = -102944;
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (y >= 0) begin
				t = x + (y >>> i); y = y - (x >>> i); x = t; z += ATAN_Q16[i];
			end else begin
				t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ATAN_Q16[i];
			end
		end
		return (z + 4) >>> 3;
	endfunction

	function automatic longint root_floor(longint v);
		longint r;
		r = 0;
		for (longint b = 1 << 17; b > 0; b >>= 1)
			if ((r + b) * (r + b) <= v) r += b;
		return r;
	endfunction

	function automatic command_t steer(longint px, longint py, longint hd,
		longint gx, longint gy);
		command_t c;
		longint dx, dy, err, ang, dvs, lin;
		dx = gx - px; dy = gy - py;
		err = heading_to_goal(dx, dy) - hd;
		if (err < -25736) err += 51472;
		else if (err > 25736) err -= 51472;
		ang = (longint'(gain_ang) * err + 1024) >>> 11;
		if (ang > 32767) ang = 32767;
		if (ang < -32768) ang = -32768;
		dvs = ang < 0 ? -ang : ang;
		if (dvs < turn_floor) dvs = turn_floor;
		if (dvs == 0) dvs = 1;
		lin = longint'(gain_lin) * root_floor(dx * dx + dy * dy) * 4 / dvs;
		if (lin > 32767) lin = 32767;
		c.lin = lin[LIN_W-1:0];
		c.ang = ang[ANG_W-1:0];
		c.arrived = (dx < 0 ? -dx : dx) <= tolerance && (dy < 0 ? -dy : dy) <= tolerance;
		return c;
	endfunction

	assign pending = commands_due.size();

	// Track register writes, predict on each pose beat, compare each result beat.
	always @(posedge clk or negedge arst_n) begin
		command_t want;
		if (!arst_n) begin
			gain_ang <= ANGULAR_GAIN_RST;
			gain_lin <= LINEAR_GAIN_RST;
			turn_floor <= MIN_TURN_RATE_RST;
			tolerance <= GOAL_TOLERANCE_RST;
			commands_due.delete();
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite) begin
				case (ggvc_reg_t'(paddr[3:2]))
					REG_ANGULAR_GAIN:   gain_ang <= pwdata[AGAIN_W-1:0];
					REG_LINEAR_GAIN:    gain_lin <= pwdata[LGAIN_W-1:0];
					REG_MIN_TURN_RATE:  turn_floor <= pwdata[MTR_W-1:0];
					REG_GOAL_TOLERANCE: tolerance <= pwdata[TOL_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (commands_due.size() == 0) begin
					$display("%0t: unexpected result lin %0d ang %0d goal %0b", $time,
						linear_velocity, angular_velocity, at_goal);
					fail_count <= fail_count + 1;
				end else begin
					want = commands_due.pop_front();
					if (want !== {linear_velocity, angular_velocity, at_goal}) begin
						$display("%0t: expected lin %0d ang %0d goal %0b, got %0d %0d %0b",
							$time, want.lin, want.ang, want.arrived, linear_velocity,
							angular_velocity, at_goal);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (push && !full)
				commands_due.push_back(steer(pose_x, pose_y, pose_heading, goal_x, goal_y));
		end
	end

endmodule

// ----- sim/go_to_goal_velocity_controller_test.sv -----
`timescale 1ns / 100ps

module go_to_goal_velocity_controller_test import ggvc_pkg::*;;

	logic clk = 0, arst_n = 0;
	logic push = 0, pop = 0, full, empty;
	logic signed [POS_W-1:0] pose_x = 0, pose_y = 0, pose_heading = 0, goal_x = 0, goal_y = 0;
	logic [LIN_W-1:0] linear_velocity;
	logic signed [ANG_W-1:0] angular_velocity;
	logic at_goal, pready;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	int fail_count, pending;
	bit stim_done = 0;

	always #10 clk = ~clk;

	go_to_goal_velocity_controller dut (.*);
	go_to_goal_velocity_controller_checker watcher (.*);

	task automatic write_reg(ggvc_reg_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// Block is idle once nothing is due and the pipeline has drained.
	task automatic settle();
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Push stays high across back to back beats and drops only for a gap.
	task automatic send_pose(logic [15:0] px, py, hd, gx, gy);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1; pose_x <= px; pose_y <= py; pose_heading <= hd; goal_x <= gx; goal_y <= gy;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic random_pose();
		logic [15:0] px, py, gx, gy, hd;
		px = $urandom; py = $urandom;
		hd = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 51472)) - 25736);
		case ($urandom_range(0, 3))
			0: begin gx = px + 16'($signed($urandom_range(0, 400)) - 200);
				gy = py + 16'($signed($urandom_range(0, 400)) - 200); end
			1: begin gx = px + 16'($signed($urandom_range(0, 8000)) - 4000);
				gy = py + 16'($signed($urandom_range(0, 8000)) - 4000); end
			default: begin gx = $urandom; gy = $urandom; end
		endcase
		send_pose(px, py, hd, gx, gy);
	endtask

	// Result side pops with random stalls.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				pop <= 0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		// Directed: extremes, pose on goal, three quadrants and three axes, out of range heading.
		send_pose(0, 0, 0, 0, 0);
		send_pose(16'h8000, 16'h8000, 16'h6488, 16'h7fff, 16'h7fff);
		send_pose(16'h7fff, 16'h7fff, 16'h9b78, 16'h8000, 16'h8000);
		send_pose(0, 0, 0, 16'h8000, 16'h7fff);
		send_pose(0, 0, 16'h7fff, 16'h8000, 16'h8000);
		send_pose(0, 0, 16'h8000, 16'h0400, 0);
		send_pose(0, 0, 0, 16'hfc00, 0);
		send_pose(0, 0, 0, 0, 16'hfc00);
		send_pose(100, 100, 0, 200, 200);
		send_pose(100, 100, 0, 202, 202);
		send_pose(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		settle();
		write_reg(REG_ANGULAR_GAIN, 0);
		write_reg(REG_MIN_TURN_RATE, 0);
		write_reg(REG_GOAL_TOLERANCE, 14'h3fff);
		write_reg(REG_LINEAR_GAIN, 10'h3ff);
		send_pose(0, 0, 0, 0, 0);
		send_pose(0, 0, 0, 16'h7fff, 16'h7fff);
		send_pose(16'h8000, 0, 0, 16'h7fff, 0);
		for (int i = 0; i < 80; i++) random_pose();
		settle();
		write_reg(REG_ANGULAR_GAIN, 12'hfff);
		write_reg(REG_MIN_TURN_RATE, 1);
		write_reg(REG_GOAL_TOLERANCE, 0);
		write_reg(REG_LINEAR_GAIN, 0);
		for (int i = 0; i < 200; i++) random_pose();
		settle();
		write_reg(REG_MIN_TURN_RATE, 14'h3fff);
		write_reg(REG_LINEAR_GAIN, 10'h3ff);
		for (int i = 0; i < 200; i++) random_pose();
		// Random settings for the rest.
		for (int p = 0; p < 6; p++) begin
			settle();
			write_reg(REG_ANGULAR_GAIN, $urandom);
			write_reg(REG_LINEAR_GAIN, $urandom);
			write_reg(REG_MIN_TURN_RATE, $urandom_range(1, 16383));
			write_reg(REG_GOAL_TOLERANCE, $urandom_range(0, 600));
			for (int i = 0; i < 95; i++) random_pose();
		end
		settle();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		if (fail_count == 0)
			$display("** go_to_goal_velocity_controller: PASSED **");
		else
			$display("** go_to_goal_velocity_controller: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** go_to_goal_velocity_controller: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
design/ggvc_pkg.sv
design/ggvc_front.sv
design/ggvc_queue.sv
design/ggvc_back.sv
design/go_to_goal_velocity_controller.sv
sim/go_to_goal_velocity_controller_checker.sv
sim/go_to_goal_velocity_controller_test.sv
